FILE: rtl/core/vprq_pkg.sv
// Package for the voxel passage-risk query block: sizes, register codes, types.
// No dependencies.
`default_nettype none
package vprq_pkg;
	localparam int GRID_SIDE_DEF = 32;
	localparam int PROB_BITS_DEF = 16;
	localparam int CFG_IDX_W     = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOWER_X  = 3'd0,
		REG_LOWER_Y  = 3'd1,
		REG_LOWER_Z  = 3'd2,
		REG_INV_RES  = 3'd3,
		REG_SIZE_X   = 3'd4,
		REG_SIZE_Y   = 3'd5,
		REG_SIZE_Z   = 3'd6,
		REG_SPARE    = 3'd7
	} reg_idx_t;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// reciprocal request / reply between top level and divider
	typedef struct packed {
		logic        start;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic        sat;
		logic [31:0] quot;
	} div_rsp_t;
endpackage
`default_nettype wire

FILE: rtl/core/vprq_map_mem.sv
// Voxel map memory with one synchronous read port and one write port; read data is registered.
// Filled by a clearing pass from the top level after reset; uses vprq_pkg.
`default_nettype none
module vprq_map_mem
	import vprq_pkg::*;
#(
	parameter int ADDR_W    = 15,
	parameter int PROB_BITS = PROB_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  we,
	input  wire [ADDR_W-1:0]     waddr,
	input  wire [PROB_BITS-1:0]  wdata,
	input  wire [ADDR_W-1:0]     raddr,
	output logic [PROB_BITS-1:0] rdata
);
	logic [PROB_BITS-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/core/vprq_recip.sv
// Restoring divider: floor(2^47 / d), saturating to 32 bits, one quotient bit a cycle.
// Uses vprq_pkg.
`default_nettype none
module vprq_recip
	import vprq_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  div_req_t  req,
	output div_rsp_t  rsp
);
	localparam int NUM_BITS = 48;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [47:0] num_q;
	logic [32:0] rem_q;
	logic [47:0] quo_q;
	logic [31:0] den_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted = {rem_q[31:0], num_q[47]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			den_q  <= '0;
			rsp    <= '0;
		end else begin
			rsp.done <= !req.start && busy_q && (cnt_q == 6'd1);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(NUM_BITS);
				num_q  <= 48'h8000_0000_0000;
				rem_q  <= '0;
				quo_q  <= '0;
				den_q  <= req.divisor;
			end else if (busy_q) begin
				num_q <= {num_q[46:0], 1'b0};
				if (!trial[32]) begin
					rem_q <= trial;
					quo_q <= {quo_q[46:0], 1'b1};
				end else begin
					rem_q <= shifted;
					quo_q <= {quo_q[46:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q   <= 1'b0;
					// final bit folded in here
					if (den_q == '0) begin
						rsp.sat  <= 1'b1;
						rsp.quot <= '1;
					end else if ((quo_q[46:31] != '0) ) begin
						rsp.sat  <= 1'b1;
						rsp.quot <= '1;
					end else begin
						rsp.sat  <= 1'b0;
						rsp.quot <= {quo_q[30:0], ~trial[32]};
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/voxel_passage_risk_query.sv
// Top level of the voxel passage-risk query block: sequencer, map, reciprocal.
// Depends on vprq_pkg, vprq_map_mem, vprq_recip.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  in       | in_valid / in_ready    | op, vox_x/y/z, pass_prob, point_x/y/z, last_point
//  out      | out_valid / out_ready  | cost_multiplier, saturated
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// After reset a clearing pass writes 1.0 into every voxel, one a cycle; no item
// is taken until it ends. A write lands at its accepting edge and leaves the
// sequencer idle, so the next item can follow at once. A query point inside the
// grid runs from accept to next accept through grid mapping per axis in S_MAP0
// and S_MAP1 (32x32 multiply), S_READ to issue the first read, eight corner reads
// from the single map port, a product multiply in S_MUL, a wrap-up in S_LAST and
// the return to S_IDLE that takes the next item. A skipped point stops at the
// first failing axis. A last point then waits in S_DIV for the reciprocal
// divider, and its result is handed out when the divider replies.
// A waiting result sits in the output register; the next item is taken
// once that register is free.
`default_nettype none
module voxel_passage_risk_query
	import vprq_pkg::*;
#(
	parameter int GRID_SIDE = GRID_SIDE_DEF,
	parameter int PROB_BITS = PROB_BITS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire               op,
	input  wire  [4:0]        vox_x,
	input  wire  [4:0]        vox_y,
	input  wire  [4:0]        vox_z,
	input  wire  [15:0]       pass_prob,
	input  wire  signed [31:0] point_x,
	input  wire  signed [31:0] point_y,
	input  wire  signed [31:0] point_z,
	input  wire               last_point,
	output logic              out_valid,
	input  wire               out_ready,
	output logic [31:0]       cost_multiplier,
	output logic              saturated,
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  wire  [CFG_IDX_W-1:0] cfg_index,
	input  wire  [31:0]       cfg_data
);
	localparam int AW     = $clog2(GRID_SIDE);
	localparam int ADDR_W = 3 * AW;
	localparam int SZW    = $clog2(GRID_SIDE + 1);
	localparam logic [PROB_BITS-1:0] PROB_ONE = PROB_BITS'(1) << (PROB_BITS - 1);
	localparam logic [ADDR_W:0] DEPTH = (ADDR_W+1)'(1) << ADDR_W;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_MAP0, S_MAP1, S_READ, S_MIN, S_MUL, S_LAST, S_DIV
	} state_t;

	// configuration
	logic signed [31:0] lower_q [3];
	logic [31:0]        inv_res_q;
	logic [5:0]         size_q [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q[0] <= -32'sd65536;
			lower_q[1] <= -32'sd65536;
			lower_q[2] <= 32'sd32768;
			inv_res_q  <= 32'd1310720;
			size_q[0]  <= 6'd32;
			size_q[1]  <= 6'd32;
			size_q[2]  <= 6'd32;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_LOWER_X: lower_q[0] <= cfg_data;
				REG_LOWER_Y: lower_q[1] <= cfg_data;
				REG_LOWER_Z: lower_q[2] <= cfg_data;
				REG_INV_RES: inv_res_q  <= cfg_data;
				REG_SIZE_X:  size_q[0]  <= cfg_data[5:0];
				REG_SIZE_Y:  size_q[1]  <= cfg_data[5:0];
				REG_SIZE_Z:  size_q[2]  <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	state_t state_q;
	logic [ADDR_W:0] clr_q;
	logic [1:0]  axis_q;
	logic [3:0]  corner_q;
	logic        skip_q, last_q;
	logic signed [32:0] diff_q [3];
	logic [31:0] lo_q [3];
	logic        frac_q [3];
	logic [PROB_BITS-1:0] min_q;
	logic [31:0] prod_q;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [63:0] grid_s1;

	// map port
	logic                 we;
	logic [ADDR_W-1:0]    waddr, raddr;
	logic [PROB_BITS-1:0] wdata, rdata;
	div_req_t dreq;
	div_rsp_t drsp;

	vprq_map_mem #(.ADDR_W(ADDR_W), .PROB_BITS(PROB_BITS)) u_map (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);
	vprq_recip u_recip (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// write path straight from the input item
	logic wr_ok;
	logic [PROB_BITS-1:0] p_clip;
	always_comb begin
		wr_ok = (32'(vox_x) < GRID_SIDE) && (32'(vox_y) < GRID_SIDE) &&
			(32'(vox_z) < GRID_SIDE);
		if (PROB_BITS >= 16)
			p_clip = (PROB_BITS'(pass_prob) > PROB_ONE) ? PROB_ONE : PROB_BITS'(pass_prob);
		else
			p_clip = (32'(pass_prob) > 32'(PROB_ONE)) ? PROB_ONE : PROB_BITS'(pass_prob);
	end

	assign in_ready = (state_q == S_IDLE) && !out_valid;
	wire take = in_valid && in_ready;

	always_comb begin
		we    = 1'b0;
		waddr = {AW'(vox_x), AW'(vox_y), AW'(vox_z)};
		wdata = p_clip;
		if (state_q == S_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q[ADDR_W-1:0];
			wdata = PROB_ONE;
		end else if (take && op == OP_WRITE && wr_ok) begin
			we = 1'b1;
		end
	end

	// corner address: bit 2 picks x ceil, bit 1 y, bit 0 z
	always_comb begin
		raddr = {AW'(lo_q[0] + 32'(corner_q[2] & frac_q[0])),
			 AW'(lo_q[1] + 32'(corner_q[1] & frac_q[1])),
			 AW'(lo_q[2] + 32'(corner_q[0] & frac_q[2]))};
	end

	// shared multiplier: grid mapping, then product update
	always_comb begin
		if (state_q == S_MUL) begin
			mul_a = prod_q;
			mul_b = 32'(min_q);
		end else begin
			mul_a = diff_q[axis_q][31:0];
			mul_b = inv_res_q;
		end
		mul_p = 64'(mul_a) * 64'(mul_b);
	end

	logic [5:0] lim;
	logic [32:0] hi;
	always_comb begin
		lim = (32'(size_q[axis_q]) > GRID_SIDE) ? 6'(GRID_SIDE) : size_q[axis_q];
		hi  = 33'(grid_s1[63:32]) + 33'(grid_s1[31:0] != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			prod_q    <= 32'h8000_0000;
			out_valid <= 1'b0;
			dreq      <= '0;
			axis_q    <= '0;
			corner_q  <= '0;
		end else begin
			// divider kicked off from the wrap-up cycle of a last point
			dreq.start <= (state_q == S_LAST) && last_q;
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == DEPTH - 1'b1)
						state_q <= S_IDLE;
				end
				S_IDLE: if (take && op == OP_QUERY) begin
					diff_q[0] <= 33'(point_x) - 33'(lower_q[0]);
					diff_q[1] <= 33'(point_y) - 33'(lower_q[1]);
					diff_q[2] <= 33'(point_z) - 33'(lower_q[2]);
					last_q  <= last_point;
					skip_q  <= 1'b0;
					axis_q  <= '0;
					state_q <= S_MAP0;
				end
				S_MAP0: begin
					grid_s1 <= mul_p;
					state_q <= S_MAP1;
				end
				S_MAP1: begin
					if (diff_q[axis_q][32] || hi >= 33'(lim))
						skip_q <= 1'b1;
					lo_q[axis_q]   <= grid_s1[63:32];
					frac_q[axis_q] <= grid_s1[31:0] != '0;
					if (diff_q[axis_q][32] || hi >= 33'(lim) || axis_q == 2'd2) begin
						corner_q <= '0;
						min_q    <= PROB_ONE;
						if (diff_q[axis_q][32] || hi >= 33'(lim) || skip_q)
							state_q <= S_LAST;
						else
							state_q <= S_READ;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= S_MAP0;
					end
				end
				S_READ: begin
					corner_q <= corner_q + 4'd1;
					state_q  <= S_MIN;
				end
				S_MIN: begin
					if (rdata < min_q)
						min_q <= rdata;
					if (corner_q == 4'd8)
						state_q <= S_MUL;
					else begin
						corner_q <= corner_q + 4'd1;
						state_q  <= (corner_q == 4'd8) ? S_MUL : S_MIN;
					end
				end
				S_MUL: begin
					prod_q  <= 32'(mul_p >> (PROB_BITS - 1));
					state_q <= S_LAST;
				end
				S_LAST: begin
					if (last_q) begin
						dreq.divisor <= prod_q;
						state_q      <= S_DIV;
					end else
						state_q <= S_IDLE;
				end
				S_DIV: if (drsp.done) begin
					cost_multiplier <= drsp.quot;
					saturated       <= drsp.sat;
					out_valid       <= 1'b1;
					prod_q          <= 32'h8000_0000;
					state_q         <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// no item is taken while the map is being cleared
	a_no_take_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !in_ready) else $error("item taken during clear");
	// product never exceeds 1.0
	a_prod_bound: assert property (@(posedge clk) disable iff (!arst_n)
		prod_q <= 32'h8000_0000) else $error("product above one");
	// a result only appears after a divider reply
	a_out_from_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(drsp.done)) else $error("spurious result");
endmodule
`default_nettype wire
